[hw/rtl/mme_pkg.sv]
// ----------------------------------------------------------------------------
// mme_pkg: shared types and constants of the matrix multiply engine
// Sizes of the element stores, field widths, operation and status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package mme_pkg;

   // Largest supported matrix dimension; both stores hold MAX_DIM x MAX_DIM.
   localparam int MAX_DIM = 8;

   localparam int DEPTH   = MAX_DIM * MAX_DIM;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int CNT_W   = $clog2(MAX_DIM);
   localparam int DIM_W   = $clog2(MAX_DIM + 1);

   localparam int ELEM_W  = 16;
   localparam int PROD_W  = 2 * ELEM_W;
   localparam int VALUE_W = 35;
   localparam int ACC_W   = 36 + CNT_W;

   localparam int REG_W       = 4;
   localparam int CSR_ADDR_W  = 2;
   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 48;

   localparam longint VALUE_MAX = 64'sd17179869183;
   localparam longint VALUE_MIN = -64'sd17179869184;

   localparam logic [CSR_ADDR_W-1:0] CSR_A_ROWS = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_A_COLS = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_B_ROWS = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_B_COLS = 2'd3;

   typedef enum logic [1:0] {
      OP_WRITE_A  = 2'd0,
      OP_WRITE_B  = 2'd1,
      OP_MULTIPLY = 2'd2
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_RANGE    = 2'd1,
      ST_MISMATCH = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_ISSUE,
      S_DRAIN,
      S_EMIT
   } state_type;

   // Control that travels alongside one pair of operands into the MAC.
   typedef struct packed {
      logic vld;
      logic first;
      logic last;
   } mac_ctl_type;

   // A dimension register of zero acts as one, and one beyond MAX_DIM as MAX_DIM.
   function automatic logic [DIM_W-1:0] eff_dim(input logic [REG_W-1:0] r);
      logic [DIM_W-1:0] d;
      if (r == '0) begin
         d = DIM_W'(1);
      end else if (int'(r) > MAX_DIM) begin
         d = DIM_W'(MAX_DIM);
      end else begin
         d = DIM_W'(r);
      end
      return d;
   endfunction

   function automatic logic [ADDR_W-1:0] elem_addr(input logic [CNT_W-1:0] row,
                                                   input logic [CNT_W-1:0] col);
      return ADDR_W'(int'(row) * MAX_DIM + int'(col));
   endfunction

endpackage

`default_nettype wire

[hw/rtl/matrix_multiply_engine.sv]
// ----------------------------------------------------------------------------
// An element write gives its status word in the cycle after acceptance. A
// multiply computes the elements of C one at a time, row by row, through
// one read port per store feeding the single shared MAC; the engine takes no
// new word until the last element of C has gone to the output register.
// Reset is synchronous, active high: dimension registers return to 8, stores
// are left as they are.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix_multiply_engine (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // Configuration write port.
   input  wire logic                                csr_we,
   input  wire logic [mme_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  wire logic [mme_pkg::REG_W-1:0]           csr_wdata,
   // Request stream.
   input  wire logic                                req_tvalid,
   output      logic                                req_tready,
   // tdata, low bit up: row_index[2:0], col_index[2:0], elem_value[15:0], pad
   input  wire logic [mme_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // tuser: opcode[1:0]
   input  wire logic [1:0]                          req_tuser,
   // Response stream.
   output      logic                                rsp_tvalid,
   input  wire logic                                rsp_tready,
   // tdata, low bit up: out_row[2:0], out_col[2:0], out_value[34:0], pad
   output      logic [mme_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   // tuser: status[1:0]
   output      logic [1:0]                          rsp_tuser,
   output      logic                                rsp_tlast
);

   import mme_pkg::*;

   localparam int CMP_W = DIM_W + 3;

   // Configuration registers.
   logic [REG_W-1:0] a_rows_ff, a_cols_ff, b_rows_ff, b_cols_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_rows_ff <= REG_W'(8);
         a_cols_ff <= REG_W'(8);
         b_rows_ff <= REG_W'(8);
         b_cols_ff <= REG_W'(8);
      end else if (csr_we) begin
         case (csr_addr)
            CSR_A_ROWS: a_rows_ff <= csr_wdata;
            CSR_A_COLS: a_cols_ff <= csr_wdata;
            CSR_B_ROWS: b_rows_ff <= csr_wdata;
            CSR_B_COLS: b_cols_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic [DIM_W-1:0] ar, ac, br, bc;
   assign ar = eff_dim(a_rows_ff);
   assign ac = eff_dim(a_cols_ff);
   assign br = eff_dim(b_rows_ff);
   assign bc = eff_dim(b_cols_ff);

   // Request fields.
   opcode_type        req_op;
   logic [2:0]        req_row, req_col;
   logic [ELEM_W-1:0] req_value;
   logic              req_acc;

   assign req_op    = opcode_type'(req_tuser);
   assign req_row   = req_tdata[2:0];
   assign req_col   = req_tdata[5:3];
   assign req_value = req_tdata[21:6];
   assign req_acc   = req_tvalid && req_tready;

   logic a_oob, b_oob;
   assign a_oob = (CMP_W'(req_row) >= CMP_W'(ar)) || (CMP_W'(req_col) >= CMP_W'(ac));
   assign b_oob = (CMP_W'(req_row) >= CMP_W'(br)) || (CMP_W'(req_col) >= CMP_W'(bc));

   // Sequencer state.
   state_type        state_ff, state_in;
   logic [CNT_W-1:0] i_ff, i_in, j_ff, j_in, k_ff, k_in;
   mac_ctl_type      issue_ctl, rd_ctl_ff;

   logic i_end, j_end, k_end, elem_last;
   assign i_end     = (DIM_W'(i_ff) + DIM_W'(1)) == ar;
   assign j_end     = (DIM_W'(j_ff) + DIM_W'(1)) == bc;
   assign k_end     = (DIM_W'(k_ff) + DIM_W'(1)) == ac;
   assign elem_last = i_end && j_end;

   // Output register.
   logic                      rsp_valid_ff;
   status_type                rsp_status_ff;
   logic [2:0]                rsp_row_ff, rsp_col_ff;
   logic signed [VALUE_W-1:0] rsp_value_ff;
   logic                      rsp_last_ff;
   logic                      out_free;

   assign out_free = !rsp_valid_ff || rsp_tready;

   // Store and MAC connections.
   logic                      a_we, b_we;
   logic [ADDR_W-1:0]         wr_addr, a_raddr, b_raddr;
   logic [ELEM_W-1:0]         a_rdata, b_rdata;
   logic                      mac_done;
   logic signed [VALUE_W-1:0] mac_value;

   logic                      load;
   status_type                ld_status;
   logic [2:0]                ld_row, ld_col;
   logic signed [VALUE_W-1:0] ld_value;
   logic                      ld_last;

   assign wr_addr = elem_addr(CNT_W'(req_row), CNT_W'(req_col));
   assign a_raddr = elem_addr(i_ff, k_ff);
   assign b_raddr = elem_addr(k_ff, j_ff);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_acc && req_op == OP_MULTIPLY && ac == br) begin
               state_in = S_ISSUE;
            end
         end
         S_ISSUE: begin
            if (k_end) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (mac_done) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               state_in = elem_last ? S_IDLE : S_ISSUE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req_tready = 1'b0;
      a_we       = 1'b0;
      b_we       = 1'b0;
      load       = 1'b0;
      ld_status  = ST_OK;
      ld_row     = '0;
      ld_col     = '0;
      ld_value   = '0;
      ld_last    = 1'b1;
      issue_ctl  = '0;
      i_in       = i_ff;
      j_in       = j_ff;
      k_in       = k_ff;
      case (state_ff)
         S_IDLE: begin
            req_tready = out_free;
            if (req_acc) begin
               case (req_op)
                  OP_WRITE_A: begin
                     load = 1'b1;
                     if (a_oob) begin
                        ld_status = ST_RANGE;
                     end else begin
                        a_we = 1'b1;
                     end
                  end
                  OP_WRITE_B: begin
                     load = 1'b1;
                     if (b_oob) begin
                        ld_status = ST_RANGE;
                     end else begin
                        b_we = 1'b1;
                     end
                  end
                  OP_MULTIPLY: begin
                     if (ac != br) begin
                        load      = 1'b1;
                        ld_status = ST_MISMATCH;
                     end else begin
                        i_in = '0;
                        j_in = '0;
                        k_in = '0;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_ISSUE: begin
            issue_ctl.vld   = 1'b1;
            issue_ctl.first = (k_ff == '0);
            issue_ctl.last  = k_end;
            k_in            = k_end ? '0 : k_ff + CNT_W'(1);
         end
         S_DRAIN: ;
         S_EMIT: begin
            if (out_free) begin
               load     = 1'b1;
               ld_row   = 3'(i_ff);
               ld_col   = 3'(j_ff);
               ld_value = mac_value;
               ld_last  = elem_last;
               if (j_end) begin
                  j_in = '0;
                  i_in = i_ff + CNT_W'(1);
               end else begin
                  j_in = j_ff + CNT_W'(1);
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rd_ctl_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rd_ctl_ff <= issue_ctl;
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      i_ff <= i_in;
      j_ff <= j_in;
      k_ff <= k_in;
      if (load) begin
         rsp_status_ff <= ld_status;
         rsp_row_ff    <= ld_row;
         rsp_col_ff    <= ld_col;
         rsp_value_ff  <= ld_value;
         rsp_last_ff   <= ld_last;
      end
   end

   mme_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_a_ram (
      .clock (clock),
      .we    (a_we),
      .waddr (wr_addr),
      .wdata (req_value),
      .raddr (a_raddr),
      .rdata (a_rdata)
   );

   mme_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_b_ram (
      .clock (clock),
      .we    (b_we),
      .waddr (wr_addr),
      .wdata (req_value),
      .raddr (b_raddr),
      .rdata (b_rdata)
   );

   mme_mac u_mac (
      .clock     (clock),
      .reset     (reset),
      .in_ctl    (rd_ctl_ff),
      .a_value   (a_rdata),
      .b_value   (b_rdata),
      .done      (mac_done),
      .sum_value (mac_value)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_TDATA_W - VALUE_W - 6)'(0), rsp_value_ff, rsp_col_ff, rsp_row_ff};
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

   // A finished dot product only ever arrives while the sequencer waits for it.
   a_done_in_drain: assert property (@(posedge clock) disable iff (reset)
      mac_done |-> state_ff == S_DRAIN)
      else $error("MAC result arrived outside the drain state");

   // Error status words always close their item.
   a_err_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != ST_OK) |-> rsp_tlast)
      else $error("error status word without last");

   // A multiply with matching dimensions starts issuing operands next cycle.
   a_mul_starts: assert property (@(posedge clock) disable iff (reset)
      (req_acc && req_op == OP_MULTIPLY && ac == br) |=> state_ff == S_ISSUE)
      else $error("multiply did not start issuing");

endmodule

`default_nettype wire

[hw/rtl/mme_ram.sv]
// ----------------------------------------------------------------------------
// mme_ram: generic simple dual-port RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module mme_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output      logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

[hw/rtl/mme_mac.sv]
// ----------------------------------------------------------------------------
// mme_mac: shared multiply-accumulate unit
// Registered 16x16 signed product, then an accumulator that restarts on the
// first pair of a dot product and pulses done after the last one.
// ----------------------------------------------------------------------------
`default_nettype none

module mme_mac (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire mme_pkg::mac_ctl_type               in_ctl,
   input  wire logic signed [mme_pkg::ELEM_W-1:0]  a_value,
   input  wire logic signed [mme_pkg::ELEM_W-1:0]  b_value,
   output      logic                               done,
   output      logic signed [mme_pkg::VALUE_W-1:0] sum_value
);

   import mme_pkg::*;

   localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(VALUE_MAX);
   localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(VALUE_MIN);

   logic signed [PROD_W-1:0] prod_ff, prod_in;
   mac_ctl_type              pctl_ff;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic                     done_ff;

   assign prod_in = a_value * b_value;
   assign acc_in  = pctl_ff.first ? ACC_W'(prod_ff) : acc_ff + ACC_W'(prod_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         pctl_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         pctl_ff <= in_ctl;
         done_ff <= pctl_ff.vld && pctl_ff.last;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (pctl_ff.vld) begin
         acc_ff <= acc_in;
      end
   end

   always_comb begin
      if (acc_ff > SAT_HI) begin
         sum_value = VALUE_W'(SAT_HI);
      end else if (acc_ff < SAT_LO) begin
         sum_value = VALUE_W'(SAT_LO);
      end else begin
         sum_value = VALUE_W'(acc_ff);
      end
   end

   assign done = done_ff;

endmodule

`default_nettype wire

[sim/tb_matrix_multiply_engine.sv]
// ----------------------------------------------------------------------------
// tb_matrix_multiply_engine: self-checking bench for the matrix multiply engine
// Loads elements of A and B over the request stream, multiplies and compares
// every response word with a cycle-free model of C = A x B kept in the bench.
// ----------------------------------------------------------------------------
module tb_matrix_multiply_engine;
   timeunit 1ns;
   timeprecision 1ps;

   import mme_pkg::*;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int RANDOM_WORDS  = 310;
   localparam int SETTLE_CYCLES = 20;

   typedef struct {
      logic [1:0]  op;
      logic [2:0]  row;
      logic [2:0]  col;
      logic [15:0] value;
   } request_word_type;

   typedef struct {
      logic [1:0]  status;
      logic [2:0]  row;
      logic [2:0]  col;
      logic [34:0] value;
      logic        last;
   } result_word_type;

   logic                   clock;
   logic                   reset      = 1'b1;
   logic                   csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_addr   = '0;
   logic [REG_W-1:0]       csr_wdata  = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [1:0]             req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [1:0]             rsp_tuser;
   logic                   rsp_tlast;

   matrix_multiply_engine u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   request_word_type request_words[$];
   request_word_type batch[$];
   request_word_type next_word;
   result_word_type  results_due[$];

   // Model of the engine: element stores and dimension registers.
   logic [15:0] a_elem [MAX_DIM*MAX_DIM];
   logic [15:0] b_elem [MAX_DIM*MAX_DIM];
   logic [3:0]  dim_reg [4];

   // Stimulus side bookkeeping.
   bit          a_written [MAX_DIM*MAX_DIM];
   bit          b_written [MAX_DIM*MAX_DIM];
   int          g_ar, g_ac, g_br, g_bc;
   int          phase_no      = 0;
   int          random_words  = 0;
   int          issued        = 0;
   int          accepted      = 0;
   int          send_idle_pct = 0;
   int          stall_pct     = 0;
   int          errors        = 0;
   int unsigned cycle_count   = 0;
   logic        req_fired     = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int dim_in_use(logic [3:0] r);
      if (r == 4'd0) return 1;
      if (r > MAX_DIM) return MAX_DIM;
      return int'(r);
   endfunction

   task automatic execute_request(request_word_type w);
      result_word_type r;
      int              ar, ac, br, bc, nr, nc;
      longint          sum;
      ar = dim_in_use(dim_reg[CSR_A_ROWS]);
      ac = dim_in_use(dim_reg[CSR_A_COLS]);
      br = dim_in_use(dim_reg[CSR_B_ROWS]);
      bc = dim_in_use(dim_reg[CSR_B_COLS]);
      r = '{status: ST_OK, row: 3'd0, col: 3'd0, value: 35'd0, last: 1'b1};
      case (w.op)
         OP_WRITE_A, OP_WRITE_B: begin
            nr = (w.op == OP_WRITE_A) ? ar : br;
            nc = (w.op == OP_WRITE_A) ? ac : bc;
            if (w.row >= nr || w.col >= nc) begin
               r.status = ST_RANGE;
            end else if (w.op == OP_WRITE_A) begin
               a_elem[w.row * MAX_DIM + w.col] = w.value;
            end else begin
               b_elem[w.row * MAX_DIM + w.col] = w.value;
            end
            results_due.push_back(r);
         end
         OP_MULTIPLY: begin
            if (ac != br) begin
               r.status = ST_MISMATCH;
               results_due.push_back(r);
            end else begin
               for (int i = 0; i < ar; i++) begin
                  for (int j = 0; j < bc; j++) begin
                     sum = 0;
                     for (int k = 0; k < ac; k++) begin
                        sum += longint'($signed(a_elem[i * MAX_DIM + k]))
                             * longint'($signed(b_elem[k * MAX_DIM + j]));
                     end
                     if (sum > VALUE_MAX) sum = VALUE_MAX;
                     if (sum < VALUE_MIN) sum = VALUE_MIN;
                     r.row   = 3'(i);
                     r.col   = 3'(j);
                     r.value = sum[34:0];
                     r.last  = (i == ar - 1 && j == bc - 1);
                     results_due.push_back(r);
                  end
               end
            end
         end
         default: ;
      endcase
   endtask

   // Request driver: a word stays on the bus until the engine takes it.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fired) begin
         if (request_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            next_word = request_words.pop_front();
            req_tvalid <= 1'b1;
            req_tuser  <= next_word.op;
            req_tdata  <= {2'b00, next_word.value, next_word.col, next_word.row};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin : observe
      result_word_type want, got;
      if (reset) begin
         foreach (dim_reg[n]) dim_reg[n] = 4'd8;
      end else begin
         if (csr_we) dim_reg[csr_addr] = csr_wdata;
         if (req_tvalid && req_tready) begin
            execute_request('{op: req_tuser, row: req_tdata[2:0], col: req_tdata[5:3],
                              value: req_tdata[21:6]});
            accepted++;
         end
         if (rsp_tvalid && rsp_tready) begin
            got = '{status: rsp_tuser, row: rsp_tdata[2:0], col: rsp_tdata[5:3],
                    value: rsp_tdata[40:6], last: rsp_tlast};
            if (results_due.size() == 0) begin
               errors++;
               $write("%0t: unexpected word, expected none, ", $time);
               $display("got status %0d row %0d col %0d value %0d last %0d",
                        got.status, got.row, got.col, $signed(got.value), got.last);
            end else begin
               want = results_due.pop_front();
               if (got.status !== want.status || got.row !== want.row || got.col !== want.col
                   || got.value !== want.value || got.last !== want.last) begin
                  errors++;
                  $write("%0t: mismatch, expected status %0d row %0d col %0d value %0d last %0d",
                         $time, want.status, want.row, want.col, $signed(want.value),
                         want.last);
                  $display(", got status %0d row %0d col %0d value %0d last %0d",
                           got.status, got.row, got.col, $signed(got.value), got.last);
               end
            end
         end
      end
      req_fired <= !reset && req_tvalid && req_tready;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   function automatic logic [15:0] rand_elem();
      case ($urandom_range(9))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic int pick_dim();
      return ($urandom_range(9) < 7) ? $urandom_range(1, 3) : $urandom_range(1, MAX_DIM);
   endfunction

   // Several register values map onto the same size, so vary the encoding.
   function automatic logic [3:0] reg_for_dim(int d);
      if (d == 1) return $urandom_range(1) ? 4'd0 : 4'd1;
      if (d == MAX_DIM) return 4'($urandom_range(15, MAX_DIM));
      return 4'(d);
   endfunction

   task automatic send_word(logic [1:0] op, logic [2:0] row, logic [2:0] col,
                            logic [15:0] value);
      batch.push_back('{op: op, row: row, col: col, value: value});
      if (op == OP_WRITE_A && row < g_ar && col < g_ac) a_written[row * MAX_DIM + col] = 1'b1;
      if (op == OP_WRITE_B && row < g_br && col < g_bc) b_written[row * MAX_DIM + col] = 1'b1;
   endtask

   task automatic release_batch();
      foreach (batch[n]) begin
         request_words.push_back(batch[n]);
         if (batch[n].op != OP_UNUSED) random_words++;
      end
      issued += batch.size();
      batch.delete();
   endtask

   // A word with no response may still be in flight, hence the extra cycles.
   task automatic wait_drained();
      do @(negedge clock); while (accepted != issued || results_due.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(logic [CSR_ADDR_W-1:0] addr, logic [3:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= value;
   endtask

   task automatic start_phase(logic [3:0] r0, logic [3:0] r1, logic [3:0] r2, logic [3:0] r3);
      wait_drained();
      csr_write(CSR_A_ROWS, r0);
      csr_write(CSR_A_COLS, r1);
      csr_write(CSR_B_ROWS, r2);
      csr_write(CSR_B_COLS, r3);
      @(negedge clock);
      csr_we <= 1'b0;
      g_ar = dim_in_use(r0);
      g_ac = dim_in_use(r1);
      g_br = dim_in_use(r2);
      g_bc = dim_in_use(r3);
      @(posedge clock);
      case (phase_no % 4)
         0: begin send_idle_pct = 0;  stall_pct = 0;  end
         1: begin send_idle_pct = 80; stall_pct = 0;  end
         2: begin send_idle_pct = 0;  stall_pct = 80; end
         default: begin send_idle_pct = 10; stall_pct = 10; end
      endcase
      phase_no++;
   endtask

   // Every element that a multiply will read gets loaded at least once.
   task automatic load_operands();
      for (int i = 0; i < g_ar; i++)
         for (int k = 0; k < g_ac; k++)
            if (!a_written[i * MAX_DIM + k] || $urandom_range(1))
               send_word(OP_WRITE_A, 3'(i), 3'(k), rand_elem());
      for (int k = 0; k < g_br; k++)
         for (int j = 0; j < g_bc; j++)
            if (!b_written[k * MAX_DIM + j] || $urandom_range(1))
               send_word(OP_WRITE_B, 3'(k), 3'(j), rand_elem());
   endtask

   task automatic add_noise();
      logic [1:0] op;
      int         nr, nc;
      op = $urandom_range(1) ? OP_WRITE_A : OP_WRITE_B;
      nr = (op == OP_WRITE_A) ? g_ar : g_br;
      nc = (op == OP_WRITE_A) ? g_ac : g_bc;
      if ($urandom_range(3) == 0 || (nr == MAX_DIM && nc == MAX_DIM))
         send_word(OP_UNUSED, 3'($urandom), 3'($urandom), 16'($urandom));
      else if (nc == MAX_DIM || (nr < MAX_DIM && $urandom_range(1)))
         send_word(op, 3'($urandom_range(MAX_DIM - 1, nr)), 3'($urandom_range(MAX_DIM - 1)),
                   rand_elem());
      else
         send_word(op, 3'($urandom_range(MAX_DIM - 1)), 3'($urandom_range(MAX_DIM - 1, nc)),
                   rand_elem());
   endtask

   task automatic shuffle_batch();
      request_word_type held;
      int               j;
      for (int i = batch.size() - 1; i > 0; i--) begin
         j        = $urandom_range(i);
         held     = batch[i];
         batch[i] = batch[j];
         batch[j] = held;
      end
   endtask

   task automatic random_phase();
      int ar, ac, br, bc;
      ar = pick_dim();
      ac = pick_dim();
      bc = pick_dim();
      br = ac;
      if (phase_no % 8 == 5) begin
         // Now and then a full-width or full-depth product.
         if ($urandom_range(1)) begin
            ar = MAX_DIM;
            bc = MAX_DIM;
            ac = $urandom_range(1, 2);
         end else begin
            ac = MAX_DIM;
            ar = $urandom_range(1, 2);
            bc = $urandom_range(1, 2);
         end
         br = ac;
      end else if ($urandom_range(9) < 2) begin
         do br = pick_dim(); while (br == ac);
      end
      start_phase(reg_for_dim(ar), reg_for_dim(ac), reg_for_dim(br), reg_for_dim(bc));
      load_operands();
      repeat ($urandom_range(3)) add_noise();
      shuffle_batch();
      send_word(OP_MULTIPLY, 3'($urandom), 3'($urandom), 16'($urandom));
      if ($urandom_range(3) == 0) begin
         repeat ($urandom_range(1, 3)) begin
            if ($urandom_range(1))
               send_word(OP_WRITE_A, 3'($urandom_range(g_ar - 1)),
                         3'($urandom_range(g_ac - 1)), rand_elem());
            else
               send_word(OP_WRITE_B, 3'($urandom_range(g_br - 1)),
                         3'($urandom_range(g_bc - 1)), rand_elem());
         end
         send_word(OP_MULTIPLY, 3'($urandom), 3'($urandom), 16'($urandom));
      end
      release_batch();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // A is 1x2 and B is 2x1, loaded with the most negative and positive values,
      // with writes outside either matrix and a word of the unused opcode.
      start_phase(4'd0, 4'd2, 4'd2, 4'd1);
      send_word(OP_WRITE_A, 0, 0, 16'h8000);
      send_word(OP_WRITE_A, 0, 1, 16'h7FFF);
      send_word(OP_WRITE_B, 0, 0, 16'h8000);
      send_word(OP_WRITE_B, 1, 0, 16'h7FFF);
      send_word(OP_WRITE_A, 1, 0, 16'h1234);
      send_word(OP_WRITE_A, 7, 7, 16'hFFFF);
      send_word(OP_WRITE_B, 0, 1, 16'h0001);
      send_word(OP_WRITE_B, 2, 0, 16'h0001);
      send_word(OP_UNUSED, 7, 7, 16'hFFFF);
      send_word(OP_MULTIPLY, 0, 0, 16'h0000);
      release_batch();

      // Columns of A differ from rows of B.
      start_phase(4'd1, 4'd3, 4'd2, 4'd1);
      send_word(OP_WRITE_A, 0, 2, 16'h0100);
      send_word(OP_MULTIPLY, 7, 7, 16'hFFFF);
      release_batch();

      // Register values above the largest size act as the largest size.
      start_phase(4'd15, 4'd8, 4'd9, 4'd12);
      send_word(OP_WRITE_A, 7, 7, 16'h7FFF);
      send_word(OP_WRITE_B, 7, 0, 16'h8000);
      send_word(OP_WRITE_B, 0, 7, 16'h0000);
      send_word(OP_WRITE_A, 7, 0, 16'hFFFF);
      release_batch();

      // Outer product of a column and a row: four elements, the last marked.
      start_phase(4'd2, 4'd1, 4'd1, 4'd2);
      send_word(OP_WRITE_A, 1, 0, 16'h0100);
      send_word(OP_WRITE_B, 0, 1, 16'hFF00);
      send_word(OP_MULTIPLY, 0, 0, 16'h0000);
      release_batch();

      random_words = 0;
      while (random_words < RANDOM_WORDS) random_phase();

      wait_drained();
      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

[matrix_multiply_engine.f]
hw/rtl/mme_pkg.sv
hw/rtl/mme_ram.sv
hw/rtl/mme_mac.sv
hw/rtl/matrix_multiply_engine.sv
sim/tb_matrix_multiply_engine.sv
